FILE: sv/kss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kss_pkg: shared types and codes of the keyed start scheduler
// Holds the item structs, the operation and command codes and the key type.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam logic [2:0] OP_SCHEDULE = 3'd0;
    localparam logic [2:0] OP_ENQUEUE  = 3'd1;
    localparam logic [2:0] OP_MARK     = 3'd2;
    localparam logic [2:0] OP_FINISHED = 3'd3;
    localparam logic [2:0] OP_CANCEL   = 3'd4;
    localparam logic [2:0] OP_TICK     = 3'd5;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    typedef logic [159:0] t_key;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] key_low;
        logic [63:0] key_middle;
        logic [31:0] key_high;
        logic [30:0] delay_seconds;
        logic        at_front;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] target_low;
        logic [63:0] target_middle;
        logic [31:0] target_high;
        logic        scheduled_flag;
        logic [30:0] remaining_ticks;
        logic        queued_flag;
        logic [4:0]  queue_position;
        logic        overflow;
        logic        last;
    } t_out_item;

endpackage
`default_nettype wire

FILE: sv/kss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kss_ram: generic simple dual-port RAM with registered read
// One write and one read per cycle, at separate addresses; read data is registered.
// ----------------------------------------------------------------------------
module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/keyed_start_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_start_scheduler: timer, start queue and stop-after-finish tables
// Each table is a RAM walked one entry per step by a single sequencer that
// shares one key comparator and compacts entries in place.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// in        input      i_in_valid, o_in_stall, i_in_item
// out       output     o_out_valid, i_out_stall, o_out_item
//
// In a walk each entry is read in S_NEXT and compared and moved in S_EX;
// S_NEXT then finds the end and S_INSERT closes the walk. An item runs one
// to three update walks, then the timer and queue lookups. Reset clears the
// state, the output valid flag and the fill counts only. Results wait in the
// output register while the sequencer holds; input is stalled until the
// closing result is taken.
// ----------------------------------------------------------------------------
module keyed_start_scheduler #(
    parameter int TIMER_DEPTH = 16,
    parameter int QUEUE_DEPTH = 16,
    parameter int MARK_DEPTH  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire kss_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output kss_pkg::t_out_item      o_out_item
);
    localparam int TW = $clog2(TIMER_DEPTH + 1);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = $clog2(MARK_DEPTH + 1);
    localparam int TA = (TIMER_DEPTH > 1) ? $clog2(TIMER_DEPTH) : 1;
    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int MA = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int TD = (TIMER_DEPTH > 1) ? TIMER_DEPTH : 2;
    localparam int QD = (QUEUE_DEPTH > 1) ? QUEUE_DEPTH : 2;
    localparam int MD = (MARK_DEPTH > 1) ? MARK_DEPTH : 2;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;
    localparam logic [3:0] S_EX     = 4'd2;
    localparam logic [3:0] S_EMIT   = 4'd3;
    localparam logic [3:0] S_NEXT   = 4'd4;
    localparam logic [3:0] S_CLOSE  = 4'd5;
    localparam logic [3:0] S_WAIT   = 4'd6;
    localparam logic [3:0] S_INSERT = 4'd7;

    // Walk kinds.
    localparam logic [2:0] W_TDROP  = 3'd0; // timer: remove key, compact
    localparam logic [2:0] W_QDROP  = 3'd1; // queue: remove key, compact
    localparam logic [2:0] W_MDROP  = 3'd2; // marks: remove key, compact
    localparam logic [2:0] W_TICK   = 3'd3; // timer tick, compact
    localparam logic [2:0] W_QFRONT = 3'd4; // queue shift up by one
    localparam logic [2:0] W_TFIND  = 3'd5; // status: timer lookup
    localparam logic [2:0] W_QFIND  = 3'd6; // status: queue lookup

    logic [3:0]         r_state, n_state;
    logic [2:0]         r_walk, n_walk;
    kss_pkg::t_in_item  r_item, n_item;
    logic [8:0]         r_rd, n_rd;
    logic [8:0]         r_wr, n_wr;
    logic               r_hit, n_hit;
    logic               r_ovf, n_ovf;
    logic [TW-1:0]      r_tfill, n_tfill;
    logic [QW-1:0]      r_qfill, n_qfill;
    logic [MW-1:0]      r_mfill, n_mfill;
    logic               r_sched, n_sched;
    logic [30:0]        r_rem, n_rem;
    logic               r_queued, n_queued;
    logic [4:0]         r_qpos, n_qpos;
    logic               r_ovalid, n_ovalid;
    kss_pkg::t_out_item r_out, n_out;
    kss_pkg::t_out_item r_cmd, n_cmd;

    logic              t_we, q_we, m_we;
    logic [TA-1:0]     t_wa, t_ra;
    logic [QA-1:0]     q_wa, q_ra;
    logic [MA-1:0]     m_wa, m_ra;
    logic [190:0]      t_wd, t_rdata;
    kss_pkg::t_key     q_wd, q_rdata, m_wd, m_rdata;

    kss_ram #(.WIDTH(191), .DEPTH(TD)) u_timer (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rdata)
    );
    kss_ram #(.WIDTH(160), .DEPTH(QD)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(q_ra), .o_rdata(q_rdata)
    );
    kss_ram #(.WIDTH(160), .DEPTH(MD)) u_mark (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rdata)
    );

    kss_pkg::t_key key;
    kss_pkg::t_key ent_key;
    logic [30:0]   ent_cnt;
    logic [8:0]    cur_fill;
    logic          match;

    assign key = {r_item.key_high, r_item.key_middle, r_item.key_low};

    always_comb begin
        unique case (r_walk)
            W_TDROP, W_TICK, W_TFIND: begin
                ent_key  = t_rdata[190:31];
                cur_fill = 9'(r_tfill);
            end
            W_MDROP: begin
                ent_key  = m_rdata;
                cur_fill = 9'(r_mfill);
            end
            default: begin
                ent_key  = q_rdata;
                cur_fill = 9'(r_qfill);
            end
        endcase
        ent_cnt = t_rdata[30:0];
        match   = (ent_key == key);
    end

    // Returns the walk that follows a finished one for the current operation.
    function automatic logic [2:0] next_walk(input logic [2:0] op, input logic [2:0] w);
        logic [2:0] nw;
        nw = W_TFIND;
        if (op == kss_pkg::OP_CANCEL && w == W_TDROP) begin
            nw = W_QDROP;
        end else if (op == kss_pkg::OP_CANCEL && w == W_QDROP) begin
            nw = W_MDROP;
        end else if (w == W_TFIND) begin
            nw = W_QFIND;
        end
        return nw;
    endfunction

    logic out_free;
    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_walk   = r_walk;
        n_item   = r_item;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_hit    = r_hit;
        n_ovf    = r_ovf;
        n_tfill  = r_tfill;
        n_qfill  = r_qfill;
        n_mfill  = r_mfill;
        n_sched  = r_sched;
        n_rem    = r_rem;
        n_queued = r_queued;
        n_qpos   = r_qpos;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        n_cmd    = r_cmd;
        t_we = 1'b0; q_we = 1'b0; m_we = 1'b0;
        t_wa = TA'(r_wr); q_wa = QA'(r_wr); m_wa = MA'(r_wr);
        t_ra = TA'(r_rd); q_ra = QA'(r_rd); m_ra = MA'(r_rd);
        t_wd = t_rdata; q_wd = q_rdata; m_wd = m_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_ovf   = 1'b0;
                    n_hit   = 1'b0;
                    n_rd    = '0;
                    n_wr    = '0;
                    n_sched = 1'b0; n_rem = '0; n_queued = 1'b0; n_qpos = '0;
                    n_state = S_NEXT;
                    unique case (i_in_item.operation)
                        kss_pkg::OP_SCHEDULE, kss_pkg::OP_CANCEL: n_walk = W_TDROP;
                        kss_pkg::OP_ENQUEUE: n_walk = W_QDROP;
                        kss_pkg::OP_MARK, kss_pkg::OP_FINISHED: n_walk = W_MDROP;
                        kss_pkg::OP_TICK: n_walk = W_TICK;
                        default: n_walk = W_TFIND;
                    endcase
                end
            end
            S_NEXT: begin
                // Begin or continue a walk at r_rd.
                if (r_walk == W_QFRONT) begin
                    if (r_rd == 9'd0) begin
                        n_state = S_INSERT;
                    end else begin
                        n_rd    = r_rd - 9'd1;
                        q_ra    = QA'(r_rd - 9'd1);
                        n_state = S_EX;
                    end
                end else if (r_rd >= cur_fill ||
                        ((r_walk == W_TFIND || r_walk == W_QFIND) && r_hit)) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_EX;
                end
            end
            S_EX: begin
                // Read data for entry r_rd is valid here.
                n_state = S_NEXT;
                unique case (r_walk)
                    W_QFRONT: begin
                        q_we = 1'b1;
                        q_wa = QA'(r_rd + 9'd1);
                    end
                    W_TFIND: begin
                        if (match) begin
                            n_hit = 1'b1; n_sched = 1'b1; n_rem = ent_cnt;
                        end
                        n_rd = r_rd + 9'd1;
                    end
                    W_QFIND: begin
                        if (match) begin
                            n_hit = 1'b1; n_queued = 1'b1;
                            n_qpos = 5'(r_rd + 9'd1);
                        end
                        n_rd = r_rd + 9'd1;
                    end
                    W_TICK: begin
                        n_rd = r_rd + 9'd1;
                        if (ent_cnt <= 31'd1) begin
                            n_state = S_EMIT;
                            n_cmd   = '0;
                            n_cmd.command = kss_pkg::CMD_START;
                            {n_cmd.target_high, n_cmd.target_middle, n_cmd.target_low}
                                = ent_key;
                        end else begin
                            t_we = 1'b1;
                            t_wd = {ent_key, ent_cnt - 31'd1};
                            n_wr = r_wr + 9'd1;
                        end
                    end
                    default: begin
                        // Drop walks: first match is removed, rest move down (a mark only searches).
                        n_rd = r_rd + 9'd1;
                        if (r_walk == W_QDROP && !r_hit &&
                                r_item.operation == kss_pkg::OP_FINISHED) begin
                            // Queue head leaves as a start on finished.
                            n_state = S_EMIT;
                            n_hit   = 1'b1;
                            n_cmd   = '0;
                            n_cmd.command = kss_pkg::CMD_START;
                            {n_cmd.target_high, n_cmd.target_middle, n_cmd.target_low}
                                = ent_key;
                        end else if (match && !r_hit) begin
                            n_hit = 1'b1;
                            if (r_walk == W_MDROP &&
                                    r_item.operation == kss_pkg::OP_FINISHED) begin
                                n_state = S_EMIT;
                                n_cmd   = '0;
                                n_cmd.command = kss_pkg::CMD_STOP;
                                {n_cmd.target_high, n_cmd.target_middle,
                                 n_cmd.target_low} = key;
                            end
                        end else if (r_item.operation != kss_pkg::OP_MARK) begin
                            t_we = (r_walk == W_TDROP);
                            q_we = (r_walk == W_QDROP);
                            m_we = (r_walk == W_MDROP);
                            n_wr = r_wr + 9'd1;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_cmd;
                    n_state  = S_NEXT;
                end
            end
            S_INSERT: begin
                // End of a walk: fill update, insert, then choose next walk.
                n_rd  = '0;
                n_wr  = '0;
                n_hit = 1'b0;
                n_state = S_NEXT;
                n_walk  = next_walk(r_item.operation, r_walk);
                unique case (r_walk)
                    W_TDROP: begin
                        n_tfill = TW'(r_wr);
                        if (r_item.operation == kss_pkg::OP_SCHEDULE) begin
                            if (r_wr < 9'(TIMER_DEPTH)) begin
                                t_we = 1'b1;
                                t_wa = TA'(r_wr);
                                t_wd = {key, r_item.delay_seconds};
                                n_tfill = TW'(r_wr + 9'd1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    W_QDROP: begin
                        n_qfill = QW'(r_wr);
                        if (r_item.operation == kss_pkg::OP_ENQUEUE) begin
                            if (r_wr >= 9'(QUEUE_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else if (r_item.at_front) begin
                                n_walk = W_QFRONT;
                                n_rd   = r_wr;
                            end else begin
                                q_we = 1'b1;
                                q_wa = QA'(r_wr);
                                q_wd = key;
                                n_qfill = QW'(r_wr + 9'd1);
                            end
                        end
                    end
                    W_QFRONT: begin
                        q_we = 1'b1;
                        q_wa = '0;
                        q_wd = key;
                        n_qfill = r_qfill + QW'(1);
                    end
                    W_MDROP: begin
                        n_mfill = MW'(r_wr);
                        if (r_item.operation == kss_pkg::OP_MARK) begin
                            n_mfill = r_mfill;
                            if (!r_hit) begin
                                if (r_mfill < MW'(MARK_DEPTH)) begin
                                    m_we = 1'b1;
                                    m_wa = MA'(r_mfill);
                                    m_wd = key;
                                    n_mfill = r_mfill + MW'(1);
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end else if (r_item.operation == kss_pkg::OP_FINISHED) begin
                            n_walk = W_QDROP;
                        end
                    end
                    W_TICK: n_tfill = TW'(r_wr);
                    W_TFIND: ;
                    default: n_state = S_CLOSE;
                endcase
            end
            S_CLOSE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '0;
                    n_out.scheduled_flag  = r_sched;
                    n_out.remaining_ticks = r_rem;
                    n_out.queued_flag     = r_queued;
                    n_out.queue_position  = r_qpos;
                    n_out.overflow        = r_ovf;
                    n_out.last            = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tfill  <= '0;
            r_qfill  <= '0;
            r_mfill  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_tfill  <= n_tfill;
            r_qfill  <= n_qfill;
            r_mfill  <= n_mfill;
        end
        r_walk   <= n_walk;
        r_item   <= n_item;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_hit    <= n_hit;
        r_ovf    <= n_ovf;
        r_sched  <= n_sched;
        r_rem    <= n_rem;
        r_queued <= n_queued;
        r_qpos   <= n_qpos;
        r_out    <= n_out;
        r_cmd    <= n_cmd;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tfill <= TW'(TIMER_DEPTH) && r_qfill <= QW'(QUEUE_DEPTH)
        && r_mfill <= MW'(MARK_DEPTH))
        else $error("table fill above depth");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_ovalid || r_out.last)
        else $error("command result pending while idle");
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> o_out_item.command == kss_pkg::CMD_NONE)
        else $error("closing result carries a command");
endmodule
`default_nettype wire
